### src/pte_pkg.sv
// palette table engine package: field widths, operation codes, controller types
// and the word packing helper; no dependencies
package pte_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int OP_W      = 3;
    localparam int RGB_W     = 24;
    localparam int WORD_W    = 32;
    localparam int ENT_W     = 8;
    localparam int DIVD_W    = 31;
    localparam int IDX_OUT_W = 8;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_RAW = 3'd3;
    localparam logic [OP_W-1:0] OP_ASSIGN  = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clear_ptrs;
        logic res_init;
        logic res_err;
        logic div_start;
        logic div_by_depth;
        logic div_step;
        logic search_start;
        logic search_step;
        logic res_hit;
        logic add_write;
        logic lk_read;
        logic lk_take;
        logic wr_entry;
        logic wr_raw;
        logic set_ptrs;
        logic publish;
    } pte_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            div_last;
        logic            hit;
        logic            search_done;
        logic            out_free;
    } pte_status_t;

    // rgb scaled by 0x100 with opaque alpha in the low byte
    function automatic logic [WORD_W-1:0] make_word(input logic [RGB_W-1:0] rgb);
        make_word = {rgb, ALPHA_OPAQUE};
    endfunction

endpackage

### src/pte_in_if.sv
// request channel of the palette table engine: valid, ready and operation fields
// depends on pte_pkg
interface pte_in_if;
    import pte_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [RGB_W-1:0]     rgb_value;
    logic [WORD_W-1:0]    raw_word;
    logic [ENT_W-1:0]     entry_index;
    logic [DIVD_W-1:0]    color_number;

    modport source (
        output valid, opcode, rgb_value, raw_word, entry_index, color_number,
        input  ready
    );

    modport sink (
        input  valid, opcode, rgb_value, raw_word, entry_index, color_number,
        output ready
    );

endinterface

### src/pte_out_if.sv
// response channel of the palette table engine: valid, ready and result fields
// depends on pte_pkg
interface pte_out_if;
    import pte_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] result_index;
    logic [WORD_W-1:0]    color_word;
    logic                 was_present;
    logic                 error;

    modport source (
        output valid, result_index, color_word, was_present, error,
        input  ready
    );

    modport sink (
        input  valid, result_index, color_word, was_present, error,
        output ready
    );

endinterface

### src/pte_ctrl.sv
// palette table engine controller: one-hot sequencer; each operation passes decode,
// the remainder, search or memory steps it needs, and result hand-off; uses pte_pkg
module pte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pte_pkg::pte_status_t status,
    output pte_pkg::pte_cmd_t    cmd
);
    import pte_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_SEARCH = 9'b000001000,
        S_ADDWR  = 9'b000010000,
        S_LKRD   = 9'b000100000,
        S_LKDATA = 9'b001000000,
        S_WRITE  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_init = 1'b1;
                case (status.op)
                    OP_CLEAR:
                    begin
                        cmd.clear_ptrs = 1'b1;
                        state_next     = S_FINISH;
                    end
                    OP_ADD:
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = S_SEARCH;
                    end
                    OP_LOOKUP:
                    begin
                        if (status.size_zero)
                        begin
                            cmd.res_err = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_SET_RAW, OP_ASSIGN:
                    begin
                        // entry index reduced modulo the table depth in one step
                        cmd.div_start    = 1'b1;
                        cmd.div_by_depth = 1'b1;
                        state_next       = S_WRITE;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_LKRD;
                end
            end
            S_SEARCH:
            begin
                if (status.hit)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = S_FINISH;
                end
                else if (status.search_done)
                begin
                    state_next = S_ADDWR;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_ADDWR:
            begin
                cmd.add_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_LKRD:
            begin
                cmd.lk_read = 1'b1;
                state_next  = S_LKDATA;
            end
            S_LKDATA:
            begin
                cmd.lk_take = 1'b1;
                state_next  = S_FINISH;
            end
            S_WRITE:
            begin
                cmd.wr_entry = 1'b1;
                cmd.wr_raw   = (status.op == OP_SET_RAW);
                cmd.set_ptrs = (status.op == OP_ASSIGN);
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/pte_dp.sv
// palette table engine datapath: palette memory, size and insert pointers,
// bit-serial remainder unit, search counter, result and output registers; uses pte_pkg
module pte_dp #(
    parameter int TABLE_DEPTH = pte_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pte_pkg::pte_cmd_t               cmd,
    output pte_pkg::pte_status_t            status,
    input  logic [pte_pkg::OP_W-1:0]        opcode,
    input  logic [pte_pkg::RGB_W-1:0]       rgb_value,
    input  logic [pte_pkg::WORD_W-1:0]      raw_word,
    input  logic [pte_pkg::ENT_W-1:0]       entry_index,
    input  logic [pte_pkg::DIVD_W-1:0]      color_number,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [pte_pkg::IDX_OUT_W-1:0]   result_index,
    output logic [pte_pkg::WORD_W-1:0]      color_word,
    output logic                            was_present,
    output logic                            error
);
    import pte_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(DIVD_W - 1);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    // control state
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  ins_reg, ins_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [OP_W-1:0]      op_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    raw_reg;
    logic [ENT_W-1:0]     ent_reg;
    logic [DIVD_W-1:0]    colr_reg;
    logic [DIVD_W-1:0]    dvd_reg;
    logic [SIZE_W-1:0]    dsr_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [CNT_W-1:0]     dcnt_reg;
    logic [SIZE_W-1:0]    scnt_reg;
    logic [IDX_W-1:0]     pidx_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic [IDX_OUT_W-1:0] res_idx_reg;
    logic [WORD_W-1:0]    res_word_reg;
    logic                 res_pres_reg;
    logic                 res_err_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [WORD_W-1:0]    out_word_reg;
    logic                 out_pres_reg;
    logic                 out_err_reg;

    logic [SIZE_W:0]   rem_sh;
    logic              rem_ge;
    logic [SIZE_W-1:0] rem_new;
    logic [IDX_W-1:0]  rem_idx;
    logic [SIZE_W-1:0] ent_rem;
    logic              issue;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    // entry index modulo the depth: subtract the shifted depth wherever it fits
    function automatic logic [ENT_W-1:0] ent_wrap(input logic [ENT_W-1:0] v);
        logic [ENT_W-1:0] r;
        r = v;
        for (int k = ENT_W - 1; k >= 0; k--)
        begin
            if ((TABLE_DEPTH << k) < (1 << ENT_W))
            begin
                if (r >= ENT_W'(TABLE_DEPTH << k))
                begin
                    r = r - ENT_W'(TABLE_DEPTH << k);
                end
            end
        end
        return r;
    endfunction

    assign ent_rem = SIZE_W'(ent_wrap(ent_reg));

    // restoring remainder step, one dividend bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, dsr_reg});
    assign rem_new = rem_ge ? SIZE_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[SIZE_W-1:0];
    assign rem_idx = rem_reg[IDX_W-1:0];

    assign issue   = (scnt_reg < size_reg);
    assign rd_en   = (cmd.search_step && issue) || cmd.lk_read;
    assign rd_addr = cmd.lk_read ? rem_idx : scnt_reg[IDX_W-1:0];
    assign wr_en   = cmd.add_write || cmd.wr_entry;
    assign wr_addr = cmd.add_write ? ins_reg : rem_idx;
    assign wr_data = cmd.wr_raw ? raw_reg : word_reg;

    assign status.op          = op_reg;
    assign status.size_zero   = (size_reg == '0);
    assign status.div_last    = (dcnt_reg == DIV_LAST);
    assign status.hit         = pend_reg && (rd_data_reg == word_reg);
    assign status.search_done = !pend_reg && !issue;
    assign status.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        size_next = size_reg;
        ins_next  = ins_reg;
        if (cmd.clear_ptrs)
        begin
            size_next = '0;
            ins_next  = '0;
        end
        else if (cmd.add_write)
        begin
            if (size_reg < DEPTH_SZ)
            begin
                size_next = size_reg + 1'b1;
            end
            ins_next = (ins_reg == LAST_IDX) ? '0 : ins_reg + 1'b1;
        end
        else if (cmd.set_ptrs)
        begin
            size_next = SIZE_W'(rem_idx) + 1'b1;
            ins_next  = (rem_idx == LAST_IDX) ? '0 : rem_idx + 1'b1;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.search_start)
        begin
            pend_next = 1'b0;
        end
        else if (cmd.search_step)
        begin
            pend_next = issue;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            ins_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            ins_reg       <= ins_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            word_reg <= make_word(rgb_value);
            raw_reg  <= raw_word;
            ent_reg  <= entry_index;
            colr_reg <= color_number;
        end

        if (cmd.div_start)
        begin
            dvd_reg  <= colr_reg;
            dsr_reg  <= size_reg;
            rem_reg  <= cmd.div_by_depth ? ent_rem : '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg  <= rem_new;
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        if (cmd.search_start)
        begin
            scnt_reg <= '0;
        end
        else if (cmd.search_step && issue)
        begin
            pidx_reg <= scnt_reg[IDX_W-1:0];
            scnt_reg <= scnt_reg + 1'b1;
        end

        if (cmd.res_init)
        begin
            res_idx_reg  <= '0;
            res_word_reg <= '0;
            res_pres_reg <= 1'b0;
            res_err_reg  <= cmd.res_err;
        end
        else if (cmd.res_hit)
        begin
            res_idx_reg  <= IDX_OUT_W'(pidx_reg);
            res_word_reg <= word_reg;
            res_pres_reg <= 1'b1;
        end
        else if (cmd.add_write)
        begin
            res_idx_reg  <= IDX_OUT_W'(ins_reg);
            res_word_reg <= word_reg;
        end
        else if (cmd.lk_read)
        begin
            res_idx_reg <= IDX_OUT_W'(rem_idx);
        end
        else if (cmd.lk_take)
        begin
            res_word_reg <= rd_data_reg;
        end

        if (cmd.publish)
        begin
            out_idx_reg  <= res_idx_reg;
            out_word_reg <= res_word_reg;
            out_pres_reg <= res_pres_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    // palette memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign color_word   = out_word_reg;
    assign was_present  = out_pres_reg;
    assign error        = out_err_reg;

endmodule

### src/palette_table_engine.sv
// palette table engine top level: joins the controller and the datapath to the
// request and response channels; depends on pte_pkg, pte_in_if, pte_out_if, pte_ctrl, pte_dp
//
// one operation is in flight at a time, and the next request is taken while the
// previous response still waits in the output register. clear and unused codes go from
// decode straight to the result hand-off, set raw and assign through one memory write.
// add scans the live entries, at most 256 with the default depth, one memory read per
// cycle, and stops at the first hit or, after a miss, writes the new entry. lookup runs
// the color number through a bit-serial remainder unit that works through the 31-bit
// dividend, then reads the entry; on an empty table it skips both and sets the error flag.
// a stalled response holds the engine in its last state until the output register frees.
// there is no clearing pass after reset: entries are undefined until written.
module palette_table_engine #(
    parameter int TABLE_DEPTH = pte_pkg::TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pte_in_if.sink    request,
    pte_out_if.source response
);
    import pte_pkg::*;

    pte_cmd_t    cmd;
    pte_status_t status;

    pte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pte_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (request.opcode),
        .rgb_value    (request.rgb_value),
        .raw_word     (request.raw_word),
        .entry_index  (request.entry_index),
        .color_number (request.color_number),
        .out_ready    (response.ready),
        .out_valid    (response.valid),
        .result_index (response.result_index),
        .color_word   (response.color_word),
        .was_present  (response.was_present),
        .error        (response.error)
    );

endmodule

### src/pte_checker.sv
// port-level checks for the palette table engine, bound to the top level
// depends on palette_table_engine and pte_pkg
module pte_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pte_pkg::IDX_OUT_W-1:0] rsp_index,
    input logic [pte_pkg::WORD_W-1:0]    rsp_word,
    input logic                          rsp_present,
    input logic                          rsp_error
);

    // a pending response stays up until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // stalled response word and index hold
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_word) && $stable(rsp_index))
        else $error("response payload changed while stalled");

    // one operation at a time: no new request right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a response is launched only while a request is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response without an operation in flight");

    // an empty lookup reports nothing but the error flag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error |-> (rsp_word == '0) && (rsp_index == '0) && !rsp_present)
        else $error("error response carries data");

endmodule

bind palette_table_engine pte_checker u_pte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .rsp_valid   (response.valid),
    .rsp_ready   (response.ready),
    .rsp_index   (response.result_index),
    .rsp_word    (response.color_word),
    .rsp_present (response.was_present),
    .rsp_error   (response.error)
);

### dv/palette_table_engine_tb.sv
// self-checking testbench for palette_table_engine: directed table then random sessions,
// every response checked against the typed answer of its row or a local palette predictor
// depends on pte_pkg, pte_in_if, pte_out_if and the engine rtl
module palette_table_engine_tb;
    import pte_pkg::*;

    localparam int DEPTH           = TABLE_DEPTH_DEF;
    localparam int MAX_IDLE        = 18;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int POOL_SIZE       = 32;
    localparam int DRAIN_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIR_N           = 22;

    // codes the engine leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [RGB_W-1:0]  rgb;
        logic [WORD_W-1:0] raw;
        logic [ENT_W-1:0]  ent;
        logic [DIVD_W-1:0] cn;
    } req_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [WORD_W-1:0]    word;
        logic                 present;
        logic                 err;
    } resp_t;

    typedef struct packed {
        req_t  rq;
        logic  typed;
        resp_t want;
    } dir_row_t;

    localparam resp_t RES_NONE  = '0;
    localparam resp_t RES_EMPTY = '{8'h00, 32'h0, 1'b0, 1'b1};

    // rows with typed = 1 carry an answer read straight off the spec
    localparam dir_row_t DIR_STEPS [DIR_N] = '{
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h0}, 1'b1, RES_EMPTY},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h7fffffff}, 1'b1, RES_EMPTY},
        '{'{OP_SPARE_LO, 24'h0, 32'h0, 8'h00, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_SPARE_HI, 24'hffffff, 32'hffffffff, 8'hff, 31'h7fffffff}, 1'b1, RES_NONE},
        '{'{OP_ADD, 24'h000000, 32'h0, 8'h00, 31'h0}, 1'b1, '{8'h00, 32'h000000ff, 1'b0, 1'b0}},
        '{'{OP_ADD, 24'hffffff, 32'h0, 8'h00, 31'h0}, 1'b1, '{8'h01, 32'hffffffff, 1'b0, 1'b0}},
        '{'{OP_ADD, 24'h000000, 32'h0, 8'h00, 31'h0}, 1'b1, '{8'h00, 32'h000000ff, 1'b1, 1'b0}},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h7fffffff}, 1'b1,
          '{8'h01, 32'hffffffff, 1'b0, 1'b0}},
        '{'{OP_SET_RAW, 24'h0, 32'hffffffff, 8'hff, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_SET_RAW, 24'h0, 32'h123456ff, 8'h02, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_ASSIGN, 24'habcdef, 32'h0, 8'h02, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h5}, 1'b0, RES_NONE},
        '{'{OP_ADD, 24'habcdef, 32'h0, 8'h00, 31'h0}, 1'b0, RES_NONE},
        '{'{OP_SET_RAW, 24'h0, 32'h00000000, 8'h00, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_ADD, 24'h000000, 32'h0, 8'h00, 31'h0}, 1'b0, RES_NONE},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h0}, 1'b0, RES_NONE},
        '{'{OP_CLEAR, 24'h0, 32'h0, 8'h00, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h1}, 1'b1, RES_EMPTY},
        '{'{OP_ADD, 24'h123456, 32'h0, 8'h00, 31'h0}, 1'b0, RES_NONE},
        '{'{OP_SPARE_MID, 24'h123456, 32'h5a5a5a5a, 8'h80, 31'h2aaaaaaa}, 1'b1, RES_NONE},
        '{'{OP_ASSIGN, 24'hffffff, 32'h0, 8'h00, 31'h0}, 1'b1, RES_NONE},
        '{'{OP_LOOKUP, 24'h0, 32'h0, 8'h00, 31'h40000000}, 1'b0, RES_NONE}
    };

    logic clk;
    logic rst_n;

    pte_in_if  cmd_bus ();
    pte_out_if res_bus ();

    palette_table_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (cmd_bus),
        .response (res_bus)
    );

    // local copy of the palette state
    logic [WORD_W-1:0] palette_copy [DEPTH];
    bit                written [DEPTH];
    logic [8:0]        live_size;
    logic [ENT_W-1:0]  insert_pos;

    resp_t             awaited_results [$];
    logic [RGB_W-1:0]  shade_pool [POOL_SIZE];
    int unsigned       mismatches;
    int unsigned       idle_cycles;
    bit                calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned idle_draw();
        if (calm)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // length of the run of written entries starting at index 0
    function automatic int unsigned written_prefix();
        int unsigned n;
        n = 0;
        while (n < DEPTH && written[n])
            n++;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] opaque_word(logic [RGB_W-1:0] rgb);
        return (WORD_W'(rgb) << 8) | WORD_W'(ALPHA_OPAQUE);
    endfunction

    // applies one operation to the local palette and returns its response
    function automatic resp_t palette_apply(req_t r);
        resp_t            res;
        logic [WORD_W-1:0] w;
        int               hit;
        logic [ENT_W-1:0] slot;
        int unsigned      pos;
        res = '0;
        w   = opaque_word(r.rgb);
        hit = -1;
        case (r.op)
            OP_CLEAR:
            begin
                live_size  = '0;
                insert_pos = '0;
            end
            OP_ADD:
            begin
                for (int i = 0; i < int'(live_size); i++)
                    if (hit < 0 && palette_copy[i] == w)
                        hit = i;
                if (hit >= 0)
                begin
                    res.idx     = IDX_OUT_W'(hit);
                    res.word    = w;
                    res.present = 1'b1;
                end
                else
                begin
                    slot               = insert_pos;
                    palette_copy[slot] = w;
                    written[slot]      = 1'b1;
                    if (live_size < DEPTH)
                        live_size++;
                    insert_pos = slot + 1'b1;
                    res.idx    = slot;
                    res.word   = w;
                end
            end
            OP_LOOKUP:
            begin
                if (live_size == 0)
                    res.err = 1'b1;
                else
                begin
                    pos      = r.cn % live_size;
                    res.idx  = pos[IDX_OUT_W-1:0];
                    res.word = palette_copy[pos];
                end
            end
            OP_SET_RAW:
            begin
                palette_copy[r.ent] = r.raw;
                written[r.ent]      = 1'b1;
            end
            OP_ASSIGN:
            begin
                palette_copy[r.ent] = w;
                written[r.ent]      = 1'b1;
                live_size           = 9'(r.ent) + 9'd1;
                insert_pos          = r.ent + 1'b1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic send_txn(req_t r, logic typed, resp_t want);
        int unsigned gap;
        resp_t       pred;
        gap = idle_draw();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.opcode       <= r.op;
        cmd_bus.rgb_value    <= r.rgb;
        cmd_bus.raw_word     <= r.raw;
        cmd_bus.entry_index  <= r.ent;
        cmd_bus.color_number <= r.cn;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        pred = palette_apply(r);
        awaited_results.push_back(typed ? want : pred);
    endtask

    // sender holds off until every outstanding transaction has answered
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_item(bit grow, output bit counted);
        req_t        r;
        int unsigned pick;
        int unsigned lim;
        r.rgb   = RGB_W'($urandom);
        r.raw   = $urandom;
        r.ent   = ENT_W'($urandom);
        r.cn    = DIVD_W'($urandom);
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (grow)
            r.op = pick < 70 ? OP_ADD : pick < 95 ? OP_LOOKUP : pick < 98 ? OP_SET_RAW
                                                                            : OP_ASSIGN;
        else
            r.op = pick < 4 ? OP_CLEAR : pick < 44 ? OP_ADD : pick < 74 ? OP_LOOKUP
                 : pick < 84 ? OP_SET_RAW : pick < 94 ? OP_ASSIGN : OP_SPARE_LO;
        case (r.op)
            OP_ADD:
                if ($urandom_range(0, 9) < (grow ? 2 : 5))
                    r.rgb = shade_pool[$urandom_range(0, POOL_SIZE - 1)];
            OP_LOOKUP:
                if ($urandom_range(0, 1) == 0)
                    r.cn = DIVD_W'($urandom_range(0, 600));
            OP_SET_RAW:
                if ($urandom_range(0, 2) == 0)
                    r.raw = opaque_word(shade_pool[$urandom_range(0, POOL_SIZE - 1)]);
            OP_ASSIGN:
            begin
                // only assign where every lower entry already holds data
                lim = written_prefix();
                if (lim > DEPTH - 1)
                    lim = DEPTH - 1;
                if (lim == DEPTH - 1 && $urandom_range(0, 3) == 0)
                    r.ent = ENT_W'(DEPTH - 1);
                else
                    r.ent = ENT_W'($urandom_range(0, lim));
                if ($urandom_range(0, 1) == 0)
                    r.rgb = shade_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            OP_SPARE_LO:
            begin
                r.op    = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                counted = 1'b0;
            end
            default:
            begin
            end
        endcase
        send_txn(r, 1'b0, RES_NONE);
    endtask

    function automatic void check_result(resp_t got);
        resp_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: response with none expected: idx %h word %h present %b err %b",
                     $time, got.idx, got.word, got.present, got.err);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.idx !== want.idx)
            $display("%0t: result_index expected %h actual %h", $time, want.idx, got.idx);
        if (got.word !== want.word)
            $display("%0t: color_word expected %h actual %h", $time, want.word, got.word);
        if (got.present !== want.present)
            $display("%0t: was_present expected %b actual %b", $time, want.present,
                     got.present);
        if (got.err !== want.err)
            $display("%0t: error expected %b actual %b", $time, want.err, got.err);
        if (got !== want)
            mismatches++;
    endfunction

    // response side
    initial
    begin
        int unsigned stall;
        resp_t       got;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_draw();
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid)
                @(posedge clk);
            got = '{res_bus.result_index, res_bus.color_word, res_bus.was_present,
                    res_bus.error};
            check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("palette_table_engine_tb failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned sent;
        int unsigned span;
        bit          grow;
        bit          counted;
        req_t        wipe;
        rst_n                = 1'b0;
        mismatches           = 0;
        calm                 = 1'b0;
        live_size            = '0;
        insert_pos           = '0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.opcode       <= OP_CLEAR;
        cmd_bus.rgb_value    <= '0;
        cmd_bus.raw_word     <= '0;
        cmd_bus.entry_index  <= '0;
        cmd_bus.color_number <= '0;
        foreach (written[i])
            written[i] = 1'b0;
        foreach (shade_pool[i])
            shade_pool[i] = RGB_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_STEPS[k])
            send_txn(DIR_STEPS[k].rq, DIR_STEPS[k].typed, DIR_STEPS[k].want);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            grow = ($urandom_range(0, 4) == 0);
            span = grow ? $urandom_range(300, 360) : $urandom_range(15, 80);
            if (grow)
            begin
                // start the fill from an empty table
                wipe    = req_t'({$urandom, $urandom, $urandom, 2'($urandom)});
                wipe.op = OP_CLEAR;
                send_txn(wipe, 1'b0, RES_NONE);
                sent++;
            end
            for (int n = 0; n < int'(span) && sent < RANDOM_ITEMS; n++)
            begin
                random_item(grow, counted);
                if (counted)
                    sent++;
            end
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        cmd_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("palette_table_engine_tb passed");
        else
            $display("palette_table_engine_tb failed");
        $finish;
    end

endmodule

### sim.f
src/pte_pkg.sv
src/pte_in_if.sv
src/pte_out_if.sv
src/pte_ctrl.sv
src/pte_dp.sv
src/palette_table_engine.sv
src/pte_checker.sv
dv/palette_table_engine_tb.sv
